// ===== design/jddm_pkg.sv =====
// ----------------------------------------------------------------------------
// Joystick drive mixer package
// Shared widths, codes and payload types of the differential drive mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package jddm_pkg;

  localparam int DATA_W         = 16;
  localparam int MAG_W          = 15;
  localparam int CFG_W          = 15;
  localparam int CFG_IDX_W      = 2;
  localparam int ROOT_FRAC_BITS = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_JOY_FS = 2'd0,
    CFG_PWR_FS = 2'd1,
    CFG_WARP   = 2'd2
  } jddm_cfg_idx_e;

  typedef enum logic [1:0] {
    WARP_LINEAR = 2'd0,
    WARP_SQRT   = 2'd1,
    WARP_QROOT  = 2'd2
  } jddm_warp_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] stick_x;
    logic signed [DATA_W-1:0] stick_y;
  } jddm_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] left_drive;
    logic signed [DATA_W-1:0] right_drive;
  } jddm_out_t;

  typedef struct packed {
    logic xneg;
    logic yneg;
    logic rneg;
  } jddm_quad_t;

endpackage

`default_nettype wire

// ===== design/joystick_differential_drive_mixer_core.sv =====
// ----------------------------------------------------------------------------
// Joystick differential drive mixer
// Turns one joystick sample into left and right skid-steer motor drives.
//
// The input channel takes one (stick_x, stick_y) sample per transaction and
// the output channel gives one (left_drive, right_drive) pair per
// transaction, in order. Both use valid and ready. The configuration port
// writes joystick full scale, power full scale and warp mode; write it only
// while no transaction is in flight.
// The pipeline is made of three divider chains of 15 stages, square root and
// fourth root chains of 8 + ROOT_FRAC_BITS and 4 + ROOT_FRAC_BITS stages,
// and six single stages. One sample is taken in every cycle while the output
// is not stalled. All stages advance together; when the output register holds
// an untaken result, the whole pipeline and the input ready hold until it is
// taken, and nothing is lost or repeated. Reset empties the pipeline and loads
// full scales of 100 and fourth-root warp.
// ----------------------------------------------------------------------------
`default_nettype none

module joystick_differential_drive_mixer_core #(
  parameter int ROOT_FRAC_BITS = jddm_pkg::ROOT_FRAC_BITS
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [jddm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [jddm_pkg::CFG_W-1:0]         cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire jddm_pkg::jddm_in_t                 in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output jddm_pkg::jddm_out_t                     out_data_o
);

  localparam int MW  = jddm_pkg::MAG_W;
  localparam int F   = ROOT_FRAC_BITS;
  localparam int IW1 = MW + 2 * F;
  localparam int RW1 = (IW1 + 1) / 2;
  localparam int IW2 = RW1 + F;
  localparam int RW2 = (IW2 + 1) / 2;
  localparam int NW3 = MW + RW1;
  localparam int PW  = 2 * MW;
  localparam int QT  = 3;
  localparam int TW1 = QT + 2 * MW;
  localparam int TW3 = QT + 2 * MW;
  localparam int TW4 = TW3 + 3 * RW1;

  logic [MW-1:0] cfg_jfs_q, cfg_pfs_q;
  logic [1:0]    cfg_warp_q;
  logic [MW-1:0] j_fs, p_fs;
  logic          en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_jfs_q  <= MW'(100);
      cfg_pfs_q  <= MW'(100);
      cfg_warp_q <= jddm_pkg::WARP_QROOT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        jddm_pkg::CFG_JOY_FS: cfg_jfs_q  <= cfg_data_i;
        jddm_pkg::CFG_PWR_FS: cfg_pfs_q  <= cfg_data_i;
        jddm_pkg::CFG_WARP:   cfg_warp_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  assign j_fs = (cfg_jfs_q == '0) ? MW'(1) : cfg_jfs_q;
  assign p_fs = (cfg_pfs_q == '0) ? MW'(1) : cfg_pfs_q;

  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // Clamp and magnitude.
  logic signed [MW+1:0] lim, x_ext, y_ext, x_cl, y_cl;
  logic [MW-1:0]        ax_d, ay_d;

  always_comb begin
    lim   = {2'b00, j_fs};
    x_ext = {in_data_i.stick_x[15], in_data_i.stick_x};
    y_ext = {in_data_i.stick_y[15], in_data_i.stick_y};
    if (x_ext > lim)       x_cl = lim;
    else if (x_ext < -lim) x_cl = -lim;
    else                   x_cl = x_ext;
    if (y_ext > lim)       y_cl = lim;
    else if (y_ext < -lim) y_cl = -lim;
    else                   y_cl = y_ext;
    ax_d = x_cl[MW+1] ? MW'(-x_cl) : x_cl[MW-1:0];
    ay_d = y_cl[MW+1] ? MW'(-y_cl) : y_cl[MW-1:0];
  end

  logic          a_valid_q;
  logic [MW-1:0] a_ax_q, a_ay_q;
  logic          a_xneg_q, a_yneg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_ax_q   <= ax_d;
      a_ay_q   <= ay_d;
      a_xneg_q <= in_data_i.stick_x[15];
      a_yneg_q <= in_data_i.stick_y[15];
    end
  end

  // Cross product and difference.
  logic               b_valid_q;
  logic [PW-1:0]      b_prod_q;
  logic [MW-1:0]      b_ay_q, b_rdiff_q;
  jddm_pkg::jddm_quad_t b_quad_q;
  logic               rneg_d;
  logic [MW-1:0]      jm_ay;

  assign rneg_d = a_ax_q > a_ay_q;
  assign jm_ay  = j_fs - a_ay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (en) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_prod_q  <= PW'(a_ax_q) * PW'(jm_ay);
      b_ay_q    <= a_ay_q;
      b_rdiff_q <= rneg_d ? a_ax_q - a_ay_q : a_ay_q - a_ax_q;
      b_quad_q  <= '{xneg: a_xneg_q, yneg: a_yneg_q, rneg: rneg_d};
    end
  end

  logic                   d1_valid;
  logic [0:0][MW-1:0]     d1_quo;
  logic [TW1-1:0]         d1_tag;

  jddm_div #(
    .LANES(1), .NW(PW), .DW(MW), .QW(MW), .TW(TW1)
  ) u_div_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (b_valid_q),
    .num_i   (b_prod_q),
    .den_i   (j_fs),
    .tag_i   ({b_quad_q, b_ay_q, b_rdiff_q}),
    .valid_o (d1_valid),
    .quo_o   (d1_quo),
    .tag_o   (d1_tag)
  );

  // Left mix sum.
  logic               c_valid_q;
  logic [MW-1:0]      c_left_q, c_rdiff_q;
  jddm_pkg::jddm_quad_t c_quad_q;
  logic [MW-1:0]      d1_ay;

  assign d1_ay = d1_tag[2*MW-1:MW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (en) begin
      c_valid_q <= d1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_left_q  <= d1_ay + d1_quo[0];
      c_rdiff_q <= d1_tag[MW-1:0];
      c_quad_q  <= d1_tag[TW1-1:2*MW];
    end
  end

  // Power scaling products.
  logic                   p_valid_q;
  logic [1:0][PW-1:0]     p_prod_q;
  jddm_pkg::jddm_quad_t   p_quad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (en) begin
      p_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_prod_q[0] <= PW'(c_left_q) * PW'(p_fs);
      p_prod_q[1] <= PW'(c_rdiff_q) * PW'(p_fs);
      p_quad_q    <= c_quad_q;
    end
  end

  logic                   d2_valid;
  logic [1:0][MW-1:0]     d2_quo;
  logic [QT-1:0]          d2_tag;

  jddm_div #(
    .LANES(2), .NW(PW), .DW(MW), .QW(MW), .TW(QT)
  ) u_div_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p_valid_q),
    .num_i   (p_prod_q),
    .den_i   (j_fs),
    .tag_i   (p_quad_q),
    .valid_o (d2_valid),
    .quo_o   (d2_quo),
    .tag_o   (d2_tag)
  );

  // Square roots of left, right and full power.
  logic [2:0][IW1-1:0]    s1_op;
  logic                   s1_valid;
  logic [2:0][RW1-1:0]    s1_root;
  logic [TW3-1:0]         s1_tag;

  assign s1_op[0] = {d2_quo[0], {(2*F){1'b0}}};
  assign s1_op[1] = {d2_quo[1], {(2*F){1'b0}}};
  assign s1_op[2] = {p_fs, {(2*F){1'b0}}};

  jddm_sqrt #(
    .LANES(3), .IW(IW1), .TW(TW3), .RW(RW1)
  ) u_sqrt_sq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d2_valid),
    .op_i    (s1_op),
    .tag_i   ({d2_tag, d2_quo[0], d2_quo[1]}),
    .valid_o (s1_valid),
    .root_o  (s1_root),
    .tag_o   (s1_tag)
  );

  // Fourth roots.
  logic [2:0][IW2-1:0]    s2_op;
  logic                   s2_valid;
  logic [2:0][RW2-1:0]    s2_root;
  logic [TW4-1:0]         s2_tag;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s2_op[k] = {s1_root[k], {F{1'b0}}};
    end
  end

  jddm_sqrt #(
    .LANES(3), .IW(IW2), .TW(TW4), .RW(RW2)
  ) u_sqrt_qr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s1_valid),
    .op_i    (s2_op),
    .tag_i   ({s1_tag, s1_root[0], s1_root[1], s1_root[2]}),
    .valid_o (s2_valid),
    .root_o  (s2_root),
    .tag_o   (s2_tag)
  );

  // Root select and warp numerators.
  logic [2:0][RW1-1:0]    sq_sel;
  logic [2:0][RW1-1:0]    rt_sel;

  assign sq_sel[0] = s2_tag[3*RW1-1:2*RW1];
  assign sq_sel[1] = s2_tag[2*RW1-1:RW1];
  assign sq_sel[2] = s2_tag[RW1-1:0];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rt_sel[k] = (cfg_warp_q == jddm_pkg::WARP_QROOT) ? RW1'(s2_root[k]) : sq_sel[k];
    end
  end

  logic                   e_valid_q;
  logic [1:0][NW3-1:0]    e_num_q;
  logic [RW1-1:0]         e_den_q;
  logic [TW3-1:0]         e_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (en) begin
      e_valid_q <= s2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_num_q[0] <= NW3'(p_fs) * NW3'(rt_sel[0]);
      e_num_q[1] <= NW3'(p_fs) * NW3'(rt_sel[1]);
      e_den_q    <= rt_sel[2];
      e_tag_q    <= s2_tag[TW4-1:3*RW1];
    end
  end

  logic                   d3_valid;
  logic [1:0][MW-1:0]     d3_quo;
  logic [TW3-1:0]         d3_tag;

  jddm_div #(
    .LANES(2), .NW(NW3), .DW(RW1), .QW(MW), .TW(TW3)
  ) u_div_warp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (e_valid_q),
    .num_i   (e_num_q),
    .den_i   (e_den_q),
    .tag_i   (e_tag_q),
    .valid_o (d3_valid),
    .quo_o   (d3_quo),
    .tag_o   (d3_tag)
  );

  // Sign and quadrant mapping.
  jddm_pkg::jddm_quad_t           f_quad;
  logic                           warp_on;
  logic [MW-1:0]                  wl, wr;
  logic signed [jddm_pkg::DATA_W-1:0] l_v, r_v, l_o, r_o;
  jddm_pkg::jddm_out_t            out_q;

  always_comb begin
    f_quad  = d3_tag[TW3-1:2*MW];
    warp_on = (cfg_warp_q == jddm_pkg::WARP_SQRT) || (cfg_warp_q == jddm_pkg::WARP_QROOT);
    wl      = warp_on ? d3_quo[0] : d3_tag[2*MW-1:MW];
    wr      = warp_on ? d3_quo[1] : d3_tag[MW-1:0];
    l_v     = {1'b0, wl};
    r_v     = f_quad.rneg ? -{1'b0, wr} : {1'b0, wr};
    if (!f_quad.yneg) begin
      l_o = f_quad.xneg ? r_v : l_v;
      r_o = f_quad.xneg ? l_v : r_v;
    end else begin
      l_o = f_quad.xneg ? -l_v : -r_v;
      r_o = f_quad.xneg ? -r_v : -l_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d3_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.left_drive  <= l_o;
      out_q.right_drive <= r_o;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== design/jddm_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined divider
// Restoring division, one quotient bit per stage, several numerators that
// share one denominator, with a side tag carried along.
// ----------------------------------------------------------------------------
`default_nettype none

module jddm_div #(
  parameter int LANES = 1,
  parameter int NW    = 30,
  parameter int DW    = 15,
  parameter int QW    = 15,
  parameter int TW    = 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire logic [LANES-1:0][NW-1:0]     num_i,
  input  wire logic [DW-1:0]                den_i,
  input  wire logic [TW-1:0]                tag_i,
  output logic                              valid_o,
  output logic      [LANES-1:0][QW-1:0]     quo_o,
  output logic      [TW-1:0]                tag_o
);

  localparam int W = (NW > DW + QW) ? NW : DW + QW;

  logic [QW-1:0]                        valid_q;
  logic [QW-1:0][LANES-1:0][W-1:0]      rem_q;
  logic [QW-1:0][LANES-1:0][QW-1:0]     quo_q;
  logic [QW-1:0][DW-1:0]                den_q;
  logic [QW-1:0][TW-1:0]                tag_q;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic                       v_in;
    logic [LANES-1:0][W-1:0]    rem_in;
    logic [LANES-1:0][QW-1:0]   quo_in;
    logic [DW-1:0]              den_in;
    logic [TW-1:0]              tag_in;
    logic [LANES-1:0][W-1:0]    rem_d;
    logic [LANES-1:0][QW-1:0]   quo_d;
    logic [W-1:0]               sub;

    if (s == 0) begin : g_first
      always_comb begin
        for (int k = 0; k < LANES; k++) begin
          rem_in[k] = W'(num_i[k]);
        end
      end
      assign v_in   = valid_i;
      assign quo_in = '0;
      assign den_in = den_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign v_in   = valid_q[s-1];
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
      assign den_in = den_q[s-1];
      assign tag_in = tag_q[s-1];
    end

    assign sub = W'(den_in) << (QW - 1 - s);

    always_comb begin
      for (int k = 0; k < LANES; k++) begin
        if (rem_in[k] >= sub) begin
          rem_d[k] = rem_in[k] - sub;
          quo_d[k] = (quo_in[k] << 1) | QW'(1);
        end else begin
          rem_d[k] = rem_in[k];
          quo_d[k] = quo_in[k] << 1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        quo_q[s] <= quo_d;
        den_q[s] <= den_in;
        tag_q[s] <= tag_in;
      end
    end
  end

  assign valid_o = valid_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign tag_o   = tag_q[QW-1];

endmodule

`default_nettype wire

// ===== design/jddm_sqrt.sv =====
// ----------------------------------------------------------------------------
// Pipelined square root
// Digit-by-digit integer square root, one result bit per stage, several
// lanes in lockstep with a side tag carried along.
// ----------------------------------------------------------------------------
`default_nettype none

module jddm_sqrt #(
  parameter int LANES = 1,
  parameter int IW    = 47,
  parameter int TW    = 1,
  parameter int RW    = (IW + 1) / 2
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire logic [LANES-1:0][IW-1:0]     op_i,
  input  wire logic [TW-1:0]                tag_i,
  output logic                              valid_o,
  output logic      [LANES-1:0][RW-1:0]     root_o,
  output logic      [TW-1:0]                tag_o
);

  localparam int EW = 2 * RW;
  localparam int SW = EW + 1;

  logic [RW-1:0]                        valid_q;
  logic [RW-1:0][LANES-1:0][SW-1:0]     rem_q;
  logic [RW-1:0][LANES-1:0][SW-1:0]     root_q;
  logic [RW-1:0][TW-1:0]                tag_q;

  for (genvar s = 0; s < RW; s++) begin : g_stage
    localparam logic [SW-1:0] BIT = SW'(1) << (EW - 2 - 2 * s);

    logic                       v_in;
    logic [LANES-1:0][SW-1:0]   rem_in;
    logic [LANES-1:0][SW-1:0]   root_in;
    logic [TW-1:0]              tag_in;
    logic [LANES-1:0][SW-1:0]   rem_d;
    logic [LANES-1:0][SW-1:0]   root_d;

    if (s == 0) begin : g_first
      always_comb begin
        for (int k = 0; k < LANES; k++) begin
          rem_in[k] = SW'(op_i[k]);
        end
      end
      assign v_in    = valid_i;
      assign root_in = '0;
      assign tag_in  = tag_i;
    end else begin : g_next
      assign v_in    = valid_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign tag_in  = tag_q[s-1];
    end

    always_comb begin
      for (int k = 0; k < LANES; k++) begin
        if (rem_in[k] >= root_in[k] + BIT) begin
          rem_d[k]  = rem_in[k] - (root_in[k] + BIT);
          root_d[k] = (root_in[k] >> 1) + BIT;
        end else begin
          rem_d[k]  = rem_in[k];
          root_d[k] = root_in[k] >> 1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
        tag_q[s]  <= tag_in;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      root_o[k] = root_q[RW-1][k][RW-1:0];
    end
  end

  assign valid_o = valid_q[RW-1];
  assign tag_o   = tag_q[RW-1];

endmodule

`default_nettype wire
